// ===== design/sacl_pkg.sv =====
// sacl_pkg: shared types, constants and the address split of the cache lookup
// used by the interfaces, the controller, the datapath and the top level
// no dependencies

package sacl_pkg;

  localparam int SETS           = 64;
  localparam int WAYS           = 4;
  localparam int WORDS_PER_LINE = 8;
  localparam int AGE_BITS       = 8;

  localparam int OFF_W   = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  // tag holds word / (WORDS_PER_LINE * SETS) of a 30-bit word address
  localparam int TAG_W   = 31 - $clog2(WORDS_PER_LINE * SETS + 1);
  localparam int DADDR_W = SET_W + WAY_W + OFF_W;
  localparam int DDEPTH  = 1 << DADDR_W;
  localparam int ROW_W   = WAYS * AGE_BITS;

  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_VICTIM = 2'd1;
  localparam logic [1:0] FUNC_FILL   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [1:0]  fill_way;
    logic [31:0] fill_data;
    logic        fill_last;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set;
    logic [OFF_W-1:0] off;
  } addr_split_t;

  typedef logic [WAYS-1:0][AGE_BITS-1:0] age_row_t;

  typedef struct packed {
    logic capture;  // latch the request, start tag and age reads
    logic lookup;   // compare, update state, start data read
    logic finish;   // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic addr_split_t split_addr(logic [31:0] address);
    logic [29:0] word;
    logic [29:0] line;
    addr_split_t s;
    word  = address[31:2];
    line  = 30'(word / WORDS_PER_LINE);
    s.off = OFF_W'(word % WORDS_PER_LINE);
    s.set = SET_W'(line % SETS);
    s.tag = TAG_W'(line / SETS);
    return s;
  endfunction

endpackage

// ===== design/sacl_if.sv =====
// sacl_req_if and sacl_rsp_if: valid/ready channels of the cache lookup
// depends on sacl_pkg

interface sacl_req_if import sacl_pkg::*; ();
  logic valid;
  logic ready;
  req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ===== design/sacl_ram.sv =====
// sacl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sacl_ctrl.sv =====
// sacl_ctrl: sequencer of the cache lookup, one request at a time
// depends on sacl_pkg

module sacl_ctrl import sacl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.lookup  = (state_r == ST_LOOK);
  assign cmd.finish  = (state_r == ST_DATA) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_capture_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.lookup)
    else $error("lookup did not follow capture");

  a_lookup_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> (state_r == ST_DATA) && !in_ready)
    else $error("request taken before result was formed");

endmodule

// ===== design/sacl_dp.sv =====
// sacl_dp: tag, data and age stores, way compare, age update and result register
// depends on sacl_pkg and sacl_ram

module sacl_dp import sacl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      in_req,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_ready,
  output rsp_t      out_rsp
);

  addr_split_t      in_split;
  logic [TAG_W-1:0] tag_r;
  logic [SET_W-1:0] set_r;
  logic [OFF_W-1:0] off_r;
  logic [1:0]       func_r;
  logic [1:0]       fill_way_r;
  logic [31:0]      fill_data_r;
  logic             fill_last_r;

  logic [WAYS-1:0]  valid_r [SETS];
  logic [SETS-1:0]  age_vld_r;

  logic [TAG_W-1:0] tag_q [WAYS];
  logic [ROW_W-1:0] age_q;
  logic [31:0]      data_q;

  logic [WAYS-1:0]  match;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] old_way;
  age_row_t         age_cur;
  age_row_t         age_new;
  logic             is_read;
  logic             is_victim;
  logic             fill_go;
  logic [WAY_W-1:0] fw_idx;
  logic             age_we;
  logic             data_re;
  logic [WAY_W-1:0] data_way;

  logic             res_hit_r;
  logic [WAY_W-1:0] res_way_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  rsp_t             out_rsp_r;

  assign in_split = split_addr(in_req.address);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_r       <= in_split.tag;
      set_r       <= in_split.set;
      off_r       <= in_split.off;
      func_r      <= in_req.func;
      fill_way_r  <= in_req.fill_way;
      fill_data_r <= in_req.fill_data;
      fill_last_r <= in_req.fill_last;
    end
  end

  assign is_read   = (func_r == FUNC_READ);
  assign is_victim = (func_r == FUNC_VICTIM);
  assign fw_idx    = WAY_W'(fill_way_r);
  assign fill_go   = cmd.lookup && (func_r == FUNC_FILL) && (32'(fill_way_r) < 32'(WAYS));

  // one tag ram per way, all read at the set of the incoming request
  for (genvar g = 0; g < WAYS; g++) begin : g_tag
    sacl_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_ram (
      .clk   (clk),
      .we    (fill_go && (fw_idx == WAY_W'(g))),
      .waddr (set_r),
      .wdata (tag_r),
      .re    (cmd.capture),
      .raddr (in_split.set),
      .rdata (tag_q[g])
    );
  end

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (set_r),
    .wdata (age_new),
    .re    (cmd.capture),
    .raddr (in_split.set),
    .rdata (age_q)
  );

  assign data_way = fill_go ? fw_idx : hit_way;

  sacl_ram #(.WIDTH(32), .DEPTH(DDEPTH)) u_data_ram (
    .clk   (clk),
    .we    (fill_go),
    .waddr ({set_r, fw_idx, off_r}),
    .wdata (fill_data_r),
    .re    (data_re),
    .raddr ({set_r, data_way, off_r}),
    .rdata (data_q)
  );

  // an age row never written reads as all zero
  assign age_cur = age_vld_r[set_r] ? age_row_t'(age_q) : '0;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_r[set_r][w] && (tag_q[w] == tag_r);
    end
    hit_any = |match;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  // oldest way, lowest index wins a tie
  always_comb begin
    old_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (age_cur[w] > age_cur[old_way]) begin
        old_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (is_read) begin
        if (WAY_W'(w) == hit_way) begin
          age_new[w] = '0;
        end else if (age_cur[w] != {AGE_BITS{1'b1}}) begin
          age_new[w] = age_cur[w] + AGE_BITS'(1);
        end else begin
          age_new[w] = age_cur[w];
        end
      end else begin
        age_new[w] = (WAY_W'(w) == old_way) ? '0 : age_cur[w];
      end
    end
  end

  assign age_we  = cmd.lookup && ((is_read && hit_any) || is_victim);
  assign data_re = cmd.lookup && is_read && hit_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
      age_vld_r <= '0;
    end else begin
      if (fill_go && fill_last_r) begin
        valid_r[set_r][fw_idx] <= 1'b1;
      end
      if (age_we) begin
        age_vld_r[set_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res_hit_r <= is_read && hit_any;
      if (is_read && hit_any) begin
        res_way_r <= hit_way;
      end else if (is_victim) begin
        res_way_r <= old_way;
      end else begin
        res_way_r <= '0;
      end
    end
  end

  // result register parts the sequencer from the consumer
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rsp_r.hit       <= res_hit_r;
      out_rsp_r.way       <= 2'(res_way_r);
      out_rsp_r.read_data <= res_hit_r ? data_q : 32'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_rise_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result appeared without a finished request");

  a_hit_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && res_hit_r |-> func_r == FUNC_READ)
    else $error("hit reported for a non-read request");

endmodule

// ===== design/set_assoc_cache_lookup_lru.sv =====
// set_assoc_cache_lookup_lru: top level of the set-associative cache with age lru
// depends on sacl_pkg, sacl_if, sacl_ctrl, sacl_dp and sacl_ram
//
//   channel  dir  handshake              payload
//   in_ch    in   in_ch.valid/ready      func, address, fill_way, fill_data, fill_last
//   out_ch   out  out_ch.valid/ready     hit, way, read_data
//
// each request passes through capture with tag and age ram reads, compare and
// state update with data ram read, then load of the result register
// the registered reads of the tag, age and data rams separate these steps
// a new request is taken while an earlier result still waits in out_ch
// a stalled out_ch holds the sequencer in its last step until the result moves
// reset clears the sequencer, valid bits and age row marks at once; no clearing pass

module set_assoc_cache_lookup_lru import sacl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  sacl_req_if.sink         in_ch,
  sacl_rsp_if.source       out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;
  logic      out_valid;
  rsp_t      out_rsp;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch.req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_rsp)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.rsp   = out_rsp;

endmodule
